// ===== sv/avra_pkg.sv =====
// shared types and constants for the aligned vector range allocator
// no dependencies

package avra_pkg;

  localparam int unsigned LOWEST_VECTOR_DEF  = 32'h30;
  localparam int unsigned HIGHEST_VECTOR_DEF = 32'hDF;
  localparam int unsigned MAP_WORDS_DEF      = 8;
  localparam int unsigned WORD_BITS          = 32;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  typedef struct packed {
    logic       op;
    logic [7:0] range_count;
    logic [7:0] alignment;
    logic [7:0] first_vector;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] granted_start;
    logic [7:0] granted_count;
  } out_item_t;

  typedef struct packed {
    logic       en;
    logic [7:0] idx;
    logic       val;
  } map_wr_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } seq_res_t;

endpackage

// ===== sv/aligned_vector_range_allocator_top.sv =====
// top level of the aligned vector range allocator: sequencer, used-bit map, result register
// depends on avra_pkg, avra_map, avra_seq
//
// usage: an item on in_item (op, range_count, alignment, first_vector) is taken
// when in_valid is high and in_stall is low. allocate scans vectors upward from
// zero one per cycle, tracking the alignment phase and the length of the current
// free aligned run, and stops at the first run of range_count free vectors that
// starts at or above LOWEST_VECTOR and ends at or below HIGHEST_VECTOR. it then
// marks the run used one vector per cycle. free checks each vector of the range
// one per cycle, then clears them one per cycle.
// a zero count skips the scan and goes straight to the result. every step goes
// through the single shared pointer and map port. in_stall stays high from acceptance
// until the result is handed to the output register; one item at a time.
// each item gives exactly one result item on out_item, held in a register while
// out_stall is high; the next item may be accepted meanwhile, but its result waits.
// reset (rst_n low, synchronous) frees every vector and empties the output.

module aligned_vector_range_allocator_top import avra_pkg::*; #(
  parameter int unsigned LOWEST_VECTOR  = LOWEST_VECTOR_DEF,
  parameter int unsigned HIGHEST_VECTOR = HIGHEST_VECTOR_DEF,
  parameter int unsigned MAP_WORDS      = MAP_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic       rd_used;
  logic [7:0] rd_idx;
  map_wr_t    wr;
  seq_res_t   res;
  logic       res_taken;
  logic       out_valid_r;
  out_item_t  out_item_r;

  avra_map #(
    .MAP_WORDS(MAP_WORDS)
  ) u_map (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (rd_idx),
    .rd_used(rd_used),
    .wr     (wr)
  );

  avra_seq #(
    .LOWEST_VECTOR (LOWEST_VECTOR),
    .HIGHEST_VECTOR(HIGHEST_VECTOR),
    .MAP_WORDS     (MAP_WORDS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .rd_idx   (rd_idx),
    .rd_used  (rd_used),
    .wr       (wr),
    .res      (res),
    .res_taken(res_taken)
  );

  assign res_taken = res.valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_taken) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_item_r <= res.item;
    end
  end

  // a granted range lies inside the window
  a_grant_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.granted_count != 8'd0) |->
      ({1'b0, out_item.granted_start} >= 9'(LOWEST_VECTOR) &&
       ({1'b0, out_item.granted_start} + {1'b0, out_item.granted_count} - 9'd1)
         <= 9'(HIGHEST_VECTOR)))
    else $error("granted range outside the vector window");

  // failures carry no grant
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |->
      (out_item.granted_start == 8'd0 && out_item.granted_count == 8'd0))
    else $error("failed item carries a grant");

  // an accepted item makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after accepting an item");

endmodule

// ===== sv/avra_map.sv =====
// used-bit map of vectors, one bit read and one bit written per cycle
// depends on avra_pkg

module avra_map import avra_pkg::*; #(
  parameter int unsigned MAP_WORDS = MAP_WORDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] rd_idx,
  output logic       rd_used,
  input  map_wr_t    wr
);

  localparam int unsigned MAP_BITS = MAP_WORDS * WORD_BITS;
  localparam int unsigned IDX_W    = $clog2(MAP_BITS);

  logic [MAP_BITS-1:0] map_r;
  logic                rd_in_map;
  logic                wr_in_map;

  assign rd_in_map = ({1'b0, rd_idx} < 9'(MAP_BITS));
  assign wr_in_map = ({1'b0, wr.idx} < 9'(MAP_BITS));
  assign rd_used   = rd_in_map && map_r[rd_idx[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '0;
    end else if (wr.en && wr_in_map) begin
      map_r[wr.idx[IDX_W-1:0]] <= wr.val;
    end
  end

endmodule

// ===== sv/avra_seq.sv =====
// sequencer: one vector per cycle through a shared pointer, run counter and compare
// depends on avra_pkg; drives the map port of avra_map

module avra_seq import avra_pkg::*; #(
  parameter int unsigned LOWEST_VECTOR  = LOWEST_VECTOR_DEF,
  parameter int unsigned HIGHEST_VECTOR = HIGHEST_VECTOR_DEF,
  parameter int unsigned MAP_WORDS      = MAP_WORDS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic [7:0] rd_idx,
  input  logic     rd_used,
  output map_wr_t  wr,
  output seq_res_t res,
  input  logic     res_taken
);

  localparam logic [8:0] LO      = 9'(LOWEST_VECTOR);
  localparam logic [8:0] HI      = 9'(HIGHEST_VECTOR);
  localparam logic [8:0] MAP_LIM = 9'(MAP_WORDS * WORD_BITS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ASCAN = 5'b00010,
    S_FCHK  = 5'b00100,
    S_MARK  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic       op_r, op_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] align_r, align_nxt;
  logic [8:0] ptr_r, ptr_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] start_r, start_nxt;
  logic       run_r, run_nxt;
  status_t    status_r, status_nxt;
  logic [8:0] len_inc;
  logic [7:0] rem_inc;
  logic       last;
  logic       rd_free;

  assign len_inc = {1'b0, len_r} + 9'd1;
  assign rem_inc = rem_r + 8'd1;
  assign last    = (len_inc == {1'b0, cnt_r});
  assign rd_idx  = ptr_r[7:0];
  assign in_stall = (state_r != S_IDLE);
  // a vector beyond the map can never be granted
  assign rd_free = (ptr_r < MAP_LIM) && !rd_used;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    cnt_nxt    = cnt_r;
    align_nxt  = align_r;
    ptr_nxt    = ptr_r;
    rem_nxt    = rem_r;
    len_nxt    = len_r;
    start_nxt  = start_r;
    run_nxt    = run_r;
    status_nxt = status_r;
    wr         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_item.op;
          cnt_nxt   = in_item.range_count;
          align_nxt = (in_item.alignment == 8'd0) ? 8'd1 : in_item.alignment;
          start_nxt = in_item.first_vector;
          ptr_nxt   = (in_item.op == OP_FREE) ? {1'b0, in_item.first_vector} : 9'd0;
          rem_nxt   = 8'd0;
          len_nxt   = 8'd0;
          run_nxt   = 1'b0;
          if (in_item.range_count == 8'd0) begin
            status_nxt = (in_item.op == OP_FREE) ? ST_OK : ST_INVALID;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = (in_item.op == OP_FREE) ? S_FCHK : S_ASCAN;
          end
        end
      end
      S_ASCAN: begin
        if (run_r) begin
          if (rd_free) begin
            if (last) begin
              status_nxt = ST_OK;
              ptr_nxt    = {1'b0, start_r};
              len_nxt    = 8'd0;
              state_nxt  = S_MARK;
            end else begin
              len_nxt = len_inc[7:0];
            end
          end else begin
            run_nxt = 1'b0;
          end
        end else if (rem_r == 8'd0 && ptr_r >= LO && rd_free) begin
          start_nxt = ptr_r[7:0];
          len_nxt   = 8'd1;
          run_nxt   = 1'b1;
          if (cnt_r == 8'd1) begin
            status_nxt = ST_OK;
            len_nxt    = 8'd0;
            state_nxt  = S_MARK;
          end
        end
        if (state_nxt == S_ASCAN) begin
          if (ptr_r == HI) begin
            status_nxt = ST_NO_SPACE;
            state_nxt  = S_DONE;
          end else begin
            ptr_nxt = ptr_r + 9'd1;
            rem_nxt = (rem_inc == align_r) ? 8'd0 : rem_inc;
          end
        end
      end
      S_FCHK: begin
        if (ptr_r < LO || ptr_r > HI || !rd_used) begin
          status_nxt = ST_REJECTED;
          state_nxt  = S_DONE;
        end else if (last) begin
          status_nxt = ST_OK;
          ptr_nxt    = {1'b0, start_r};
          len_nxt    = 8'd0;
          state_nxt  = S_MARK;
        end else begin
          ptr_nxt = ptr_r + 9'd1;
          len_nxt = len_inc[7:0];
        end
      end
      S_MARK: begin
        wr.en  = 1'b1;
        wr.idx = ptr_r[7:0];
        wr.val = (op_r == OP_ALLOC);
        if (last) begin
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = ptr_r + 9'd1;
          len_nxt = len_inc[7:0];
        end
      end
      S_DONE: begin
        if (res_taken) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.valid              = (state_r == S_DONE);
    res.item.status        = status_r;
    res.item.granted_start = 8'd0;
    res.item.granted_count = 8'd0;
    if (op_r == OP_ALLOC && status_r == ST_OK) begin
      res.item.granted_start = start_r;
      res.item.granted_count = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      run_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    cnt_r    <= cnt_nxt;
    align_r  <= align_nxt;
    ptr_r    <= ptr_nxt;
    rem_r    <= rem_nxt;
    len_r    <= len_nxt;
    start_r  <= start_nxt;
    status_r <= status_nxt;
  end

  // map is written only while sweeping a granted or released range
  a_wr_only_mark: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_MARK))
    else $error("map written outside the mark sweep");

  // a sweep stays inside the window
  a_mark_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) |-> (ptr_r >= LO && ptr_r <= HI))
    else $error("map sweep outside the vector window");

  // a zero count or alignment never reaches the scan or the free check
  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ASCAN || state_r == S_FCHK) |-> (cnt_r != 8'd0 && align_r != 8'd0))
    else $error("scan running with zero count or alignment");

endmodule
